FILE: hw/rtl/prefix_polynomial_hash_macros.svh
// assertion macros shared by the prefix hash rtl
// expects signals named clock and reset in the including module
`ifndef PREFIX_POLYNOMIAL_HASH_MACROS_SVH
`define PREFIX_POLYNOMIAL_HASH_MACROS_SVH

// condition holds at every edge out of reset
`define PH_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence holds in the same cycle
`define PH_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the next cycle
`define PH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/phash_pkg.sv
// widths, codes, shared types and modular helpers of the prefix hash block
// no dependencies
package phash_pkg;

   localparam int MAX_LEN  = 1024;
   localparam int ADDR_W   = $clog2(MAX_LEN);
   localparam int LEN_W    = $clog2(MAX_LEN + 1);

   localparam int CMD_W    = 2;
   localparam int SYM_W    = 16;
   localparam int IDX_W    = 10;
   localparam int STATUS_W = 2;
   localparam int PRIME_W  = 30;
   localparam int WRAP_W   = 64;
   localparam int CMP_W    = (LEN_W > IDX_W) ? LEN_W : IDX_W;
   localparam int MUL7_W   = PRIME_W + 3;

   localparam int MUL_STEPS  = PRIME_W;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
   localparam int WRAP_DIGIT = 16;

   localparam logic [PRIME_W-1:0] HASH_PRIME = 30'd1000000007;
   localparam int SYM_OFFSET = 3;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [PRIME_W-1:0] prime;
      logic [WRAP_W-1:0]  wrap;
   } hash_word_type;

   typedef struct packed {
      logic [PRIME_W-1:0] a_prime;
      logic [PRIME_W-1:0] b_prime;
      logic [WRAP_W-1:0]  a_wrap;
      logic [WRAP_W-1:0]  b_wrap;
   } mul_op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   // 7 * x mod p for x < p, quotient taken from the top bits and fixed once
   function automatic logic [PRIME_W-1:0] mul7_prime(input logic [PRIME_W-1:0] x);
      logic [MUL7_W-1:0] x7;
      logic [2:0]        q;
      logic [MUL7_W-1:0] r;
      x7 = {x, 3'b000} - {3'b000, x};
      q  = x7[MUL7_W-1:PRIME_W];
      r  = x7 - MUL7_W'(q) * MUL7_W'(HASH_PRIME);
      if (r >= MUL7_W'(HASH_PRIME)) begin
         r = r - MUL7_W'(HASH_PRIME);
      end
      return r[PRIME_W-1:0];
   endfunction

   function automatic logic [WRAP_W-1:0] mul7_wrap(input logic [WRAP_W-1:0] x);
      return {x[WRAP_W-4:0], 3'b000} - x;
   endfunction

   function automatic logic [PRIME_W-1:0] add_prime(input logic [PRIME_W-1:0] a,
                                                    input logic [PRIME_W-1:0] b);
      logic [PRIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, HASH_PRIME}) begin
         s = s - {1'b0, HASH_PRIME};
      end
      return s[PRIME_W-1:0];
   endfunction

   function automatic logic [PRIME_W-1:0] sub_prime(input logic [PRIME_W-1:0] a,
                                                    input logic [PRIME_W-1:0] b);
      logic [PRIME_W:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (d[PRIME_W]) begin
         d = d + {1'b0, HASH_PRIME};
      end
      return d[PRIME_W-1:0];
   endfunction

   // symbol plus offset, as a residue mod p
   function automatic logic [PRIME_W-1:0] sym_prime(input logic [SYM_W-1:0] sym);
      logic [SYM_W:0] v;
      v = {sym[SYM_W-1], sym} + (SYM_W + 1)'(SYM_OFFSET);
      if (v[SYM_W]) begin
         return HASH_PRIME + {{(PRIME_W - SYM_W - 1){1'b1}}, v};
      end
      return PRIME_W'(v);
   endfunction

   // symbol plus offset, sign extended for the wrapping hash
   function automatic logic [WRAP_W-1:0] sym_wrap(input logic [SYM_W-1:0] sym);
      logic [SYM_W:0] v;
      v = {sym[SYM_W-1], sym} + (SYM_W + 1)'(SYM_OFFSET);
      return {{(WRAP_W - SYM_W - 1){v[SYM_W]}}, v};
   endfunction

endpackage

FILE: hw/rtl/phash_req_if.sv
// request channel of the prefix hash block
// depends on phash_pkg
interface phash_req_if;
   import phash_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic signed [SYM_W-1:0] symbol;
   logic [IDX_W-1:0]        left_index;
   logic [IDX_W-1:0]        right_index;

   modport source (output valid, cmd, symbol, left_index, right_index, input ready);
   modport sink   (input valid, cmd, symbol, left_index, right_index, output ready);
endinterface

FILE: hw/rtl/phash_rsp_if.sv
// response channel of the prefix hash block
// depends on phash_pkg
interface phash_rsp_if;
   import phash_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PRIME_W-1:0]    hash_prime;
   logic [WRAP_W-1:0]     hash_wrap;
   logic [STATUS_W-1:0]   status;

   modport source (output valid, hash_prime, hash_wrap, status, input ready);
   modport sink   (input valid, hash_prime, hash_wrap, status, output ready);
endinterface

FILE: hw/rtl/prefix_polynomial_hash.sv
// Prefix hash of a symbol sequence under mod 1000000007 and mod 2^64, base 7, symbol offset 3;
// uses phash_pkg, phash_req_if, phash_rsp_if, phash_mulmod and the macros header.
// Prefix hashes and base powers sit in two synchronous memories (one word holds both moduli),
// read one entry per port per cycle and written back by the append sequencer. Clear, unused
// and rejected requests go straight to the response; an append reads, multiplies by the base
// and writes back; a query with left index 0 takes its prefix as read, and any other query
// waits on the multiplier that walks the 30 bits of the power one per cycle. The next request
// is taken once the response is loaded, even while it still waits on the response channel. No
// memory initialization runs after reset: base power 0 is a constant, not a stored entry.
`include "prefix_polynomial_hash_macros.svh"

module prefix_polynomial_hash (
   input  logic        clock,
   input  logic        reset,
   phash_req_if.sink   req_ch,
   phash_rsp_if.source rsp_ch
);
   import phash_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_APP_RD  = 9'b000000010,
      S_APP_MUL = 9'b000000100,
      S_APP_WR  = 9'b000001000,
      S_Q_RD1   = 9'b000010000,
      S_Q_RD2   = 9'b000100000,
      S_Q_LD    = 9'b001000000,
      S_Q_MUL   = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   logic [LEN_W-1:0]      length_ff, length_in;
   logic [SYM_W-1:0]      sym_ff, sym_in;
   logic [IDX_W-1:0]      left_ff, left_in;
   logic [IDX_W-1:0]      right_ff, right_in;
   logic [PRIME_W-1:0]    res_prime_ff, res_prime_in;
   logic [WRAP_W-1:0]     res_wrap_ff, res_wrap_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   hash_word_type         pr_ff, pr_in;
   hash_word_type         pw_ff, pw_in;
   logic [PRIME_W-1:0]    app_hp_ff, app_hp_in;
   logic [WRAP_W-1:0]     app_hw_ff, app_hw_in;
   logic [PRIME_W-1:0]    app_pp_ff, app_pp_in;
   logic [WRAP_W-1:0]     app_pw_ff, app_pw_in;
   logic [PRIME_W-1:0]    vp_ff, vp_in;
   logic [WRAP_W-1:0]     vw_ff, vw_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PRIME_W-1:0]    rsp_prime_ff, rsp_prime_in;
   logic [WRAP_W-1:0]     rsp_wrap_ff, rsp_wrap_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   hash_word_type         prefix_mem [0:MAX_LEN-1];
   hash_word_type         power_mem  [0:MAX_LEN];
   logic [ADDR_W-1:0]     prefix_raddr, prefix_waddr;
   logic [LEN_W-1:0]      power_raddr, power_waddr;
   logic                  prefix_we, power_we;
   hash_word_type         prefix_wdata, power_wdata;
   hash_word_type         prefix_rdata_ff, power_rdata_ff;

   logic                  req_fire;
   logic                  rsp_free;
   logic                  first_pos;
   logic                  query_bad;
   logic                  seq_full;
   logic                  mul_start;
   mul_op_type            mul_op;
   mul_stat_type          mul_stat;
   logic [PRIME_W-1:0]    mul_prime;
   logic [WRAP_W-1:0]     mul_wrap;

   phash_mulmod u_mulmod (
      .clock      (clock),
      .reset      (reset),
      .start      (mul_start),
      .op         (mul_op),
      .stat       (mul_stat),
      .prod_prime (mul_prime),
      .prod_wrap  (mul_wrap)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign first_pos    = (length_ff == '0);
   assign seq_full     = (length_ff >= LEN_W'(MAX_LEN));
   assign query_bad    = (req_ch.left_index > req_ch.right_index)
                      || (CMP_W'(req_ch.right_index) >= CMP_W'(length_ff));

   // left-1 prefix comes straight off the read port, power is the copy registered in pw_ff in S_Q_RD2
   assign mul_op.a_prime = prefix_rdata_ff.prime;
   assign mul_op.b_prime = pw_ff.prime;
   assign mul_op.a_wrap  = prefix_rdata_ff.wrap;
   assign mul_op.b_wrap  = pw_ff.wrap;

   always_comb begin
      state_in      = state_ff;
      length_in     = length_ff;
      sym_in        = sym_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      res_prime_in  = res_prime_ff;
      res_wrap_in   = res_wrap_ff;
      res_status_in = res_status_ff;
      pr_in         = pr_ff;
      pw_in         = pw_ff;
      app_hp_in     = app_hp_ff;
      app_hw_in     = app_hw_ff;
      app_pp_in     = app_pp_ff;
      app_pw_in     = app_pw_ff;
      vp_in         = vp_ff;
      vw_in         = vw_ff;
      prefix_raddr  = '0;
      power_raddr   = '0;
      prefix_we     = 1'b0;
      power_we      = 1'b0;
      prefix_waddr  = ADDR_W'(length_ff);
      power_waddr   = length_ff + 1'b1;
      prefix_wdata  = '{prime: add_prime(app_hp_ff, vp_ff), wrap: app_hw_ff + vw_ff};
      power_wdata   = '{prime: app_pp_ff, wrap: app_pw_ff};
      mul_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sym_in        = req_ch.symbol;
               left_in       = req_ch.left_index;
               right_in      = req_ch.right_index;
               res_prime_in  = '0;
               res_wrap_in   = '0;
               res_status_in = ST_OK;
               state_in      = S_DONE;
               unique case (req_ch.cmd)
                  CMD_CLEAR: begin
                     length_in = '0;
                  end
                  CMD_APPEND: begin
                     if (seq_full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        state_in = S_APP_RD;
                     end
                  end
                  CMD_QUERY: begin
                     if (query_bad) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        state_in = S_Q_RD1;
                     end
                  end
                  CMD_NOP: begin
                  end
               endcase
            end
         end
         S_APP_RD: begin
            prefix_raddr = ADDR_W'(length_ff - 1'b1);
            power_raddr  = length_ff;
            state_in     = S_APP_MUL;
         end
         S_APP_MUL: begin
            app_hp_in = first_pos ? '0 : mul7_prime(prefix_rdata_ff.prime);
            app_hw_in = first_pos ? '0 : mul7_wrap(prefix_rdata_ff.wrap);
            app_pp_in = mul7_prime(first_pos ? PRIME_W'(1) : power_rdata_ff.prime);
            app_pw_in = mul7_wrap(first_pos ? WRAP_W'(1) : power_rdata_ff.wrap);
            vp_in     = sym_prime(sym_ff);
            vw_in     = sym_wrap(sym_ff);
            state_in  = S_APP_WR;
         end
         S_APP_WR: begin
            prefix_we = 1'b1;
            power_we  = 1'b1;
            length_in = length_ff + 1'b1;
            state_in  = S_DONE;
         end
         S_Q_RD1: begin
            prefix_raddr = ADDR_W'(right_ff);
            power_raddr  = LEN_W'(right_ff) - LEN_W'(left_ff) + 1'b1;
            state_in     = S_Q_RD2;
         end
         S_Q_RD2: begin
            pr_in        = prefix_rdata_ff;
            pw_in        = power_rdata_ff;
            prefix_raddr = ADDR_W'(left_ff - 1'b1);
            state_in     = S_Q_LD;
         end
         S_Q_LD: begin
            if (left_ff == '0) begin
               res_prime_in = pr_ff.prime;
               res_wrap_in  = pr_ff.wrap;
               state_in     = S_DONE;
            end else begin
               mul_start = 1'b1;
               state_in  = S_Q_MUL;
            end
         end
         S_Q_MUL: begin
            if (mul_stat.done) begin
               res_prime_in = sub_prime(pr_ff.prime, mul_prime);
               res_wrap_in  = pr_ff.wrap - mul_wrap;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_prime_in  = rsp_prime_ff;
      rsp_wrap_in   = rsp_wrap_ff;
      rsp_status_in = rsp_status_ff;
      priority if (state_ff == S_DONE && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_prime_in  = res_prime_ff;
         rsp_wrap_in   = res_wrap_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prefix_we) begin
         prefix_mem[prefix_waddr] <= prefix_wdata;
      end
      prefix_rdata_ff <= prefix_mem[prefix_raddr];
   end

   always_ff @(posedge clock) begin
      if (power_we) begin
         power_mem[power_waddr] <= power_wdata;
      end
      power_rdata_ff <= power_mem[power_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      res_prime_ff  <= res_prime_in;
      res_wrap_ff   <= res_wrap_in;
      res_status_ff <= res_status_in;
      pr_ff         <= pr_in;
      pw_ff         <= pw_in;
      app_hp_ff     <= app_hp_in;
      app_hw_ff     <= app_hw_in;
      app_pp_ff     <= app_pp_in;
      app_pw_ff     <= app_pw_in;
      vp_ff         <= vp_in;
      vw_ff         <= vw_in;
      rsp_prime_ff  <= rsp_prime_in;
      rsp_wrap_ff   <= rsp_wrap_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hash_prime = rsp_prime_ff;
   assign rsp_ch.hash_wrap  = rsp_wrap_ff;
   assign rsp_ch.status     = rsp_status_ff;

   `PH_ASSERT_ALWAYS(a_len_bound, length_ff <= LEN_W'(MAX_LEN), "sequence length past limit")
   `PH_ASSERT_NEXT(a_append_grows, state_ff == S_APP_WR, length_ff == $past(length_ff) + 1'b1, "append did not grow length")
   `PH_ASSERT_IMP(a_reject_zero, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_prime_ff == '0 && rsp_wrap_ff == '0, "rejected request carries a hash")
   `PH_ASSERT_IMP(a_mul_free, mul_start, !mul_stat.busy, "multiplier started while busy")

endmodule

FILE: hw/rtl/phash_mulmod.sv
// iterative multiplier: a*b mod p one bit per cycle, a*b mod 2^64 one 16-bit digit per cycle
// depends on phash_pkg and prefix_polynomial_hash_macros.svh
`include "prefix_polynomial_hash_macros.svh"

module phash_mulmod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  phash_pkg::mul_op_type           op,
   output phash_pkg::mul_stat_type         stat,
   output logic [phash_pkg::PRIME_W-1:0]   prod_prime,
   output logic [phash_pkg::WRAP_W-1:0]    prod_wrap
);
   import phash_pkg::*;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [MUL_CNT_W-1:0]        count_ff, count_in;
   logic [PRIME_W-1:0]          a_prime_ff, a_prime_in;
   logic [PRIME_W-1:0]          b_prime_ff, b_prime_in;
   logic [PRIME_W-1:0]          run_prime_ff, run_prime_in;
   logic [WRAP_W-1:0]           a_wrap_ff, a_wrap_in;
   logic [WRAP_W-1:0]           b_wrap_ff, b_wrap_in;
   logic [WRAP_W-1:0]           run_wrap_ff, run_wrap_in;
   logic [PRIME_W+1:0]          step_sum;
   logic [PRIME_W+1:0]          step_red;
   logic [WRAP_W+WRAP_DIGIT-1:0] part;

   always_comb begin
      busy_in      = busy_ff;
      done_in      = 1'b0;
      count_in     = count_ff;
      a_prime_in   = a_prime_ff;
      b_prime_in   = b_prime_ff;
      run_prime_in = run_prime_ff;
      a_wrap_in    = a_wrap_ff;
      b_wrap_in    = b_wrap_ff;
      run_wrap_in  = run_wrap_ff;

      // horner step, msb of b first: 2*run + bit*a stays below 3p
      step_sum = {1'b0, run_prime_ff, 1'b0}
               + (b_prime_ff[PRIME_W-1] ? {2'b00, a_prime_ff} : '0);
      priority if (step_sum >= {1'b0, HASH_PRIME, 1'b0}) begin
         step_red = step_sum - {1'b0, HASH_PRIME, 1'b0};
      end else if (step_sum >= {2'b00, HASH_PRIME}) begin
         step_red = step_sum - {2'b00, HASH_PRIME};
      end else begin
         step_red = step_sum;
      end

      part = a_wrap_ff * b_wrap_ff[WRAP_DIGIT-1:0];

      if (start) begin
         busy_in      = 1'b1;
         count_in     = '0;
         a_prime_in   = op.a_prime;
         b_prime_in   = op.b_prime;
         run_prime_in = '0;
         a_wrap_in    = op.a_wrap;
         b_wrap_in    = op.b_wrap;
         run_wrap_in  = '0;
      end else if (busy_ff) begin
         run_prime_in = step_red[PRIME_W-1:0];
         b_prime_in   = {b_prime_ff[PRIME_W-2:0], 1'b0};
         run_wrap_in  = run_wrap_ff + part[WRAP_W-1:0];
         a_wrap_in    = a_wrap_ff << WRAP_DIGIT;
         b_wrap_in    = b_wrap_ff >> WRAP_DIGIT;
         count_in     = count_ff + 1'b1;
         if (count_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_prime_ff   <= a_prime_in;
      b_prime_ff   <= b_prime_in;
      run_prime_ff <= run_prime_in;
      a_wrap_ff    <= a_wrap_in;
      b_wrap_ff    <= b_wrap_in;
      run_wrap_ff  <= run_wrap_in;
   end

   assign stat.busy  = busy_ff;
   assign stat.done  = done_ff;
   assign prod_prime = run_prime_ff;
   assign prod_wrap  = run_wrap_ff;

   `PH_ASSERT_NEXT(a_start_busy, start, busy_ff, "multiplier not busy after start")
   `PH_ASSERT_IMP(a_run_reduced, busy_ff, run_prime_ff < HASH_PRIME, "partial product not reduced")
   `PH_ASSERT_NEXT(a_done_pulse, done_ff, !done_ff, "done held longer than one cycle")

endmodule

FILE: test/tb_prefix_polynomial_hash.sv
// self-checking bench of prefix_polynomial_hash: clear, append, nop and substring query requests
// are checked against a prefix hash predictor under both moduli, with random idling on both sides
// depends on phash_pkg, phash_req_if, phash_rsp_if and the block's rtl
module tb_prefix_polynomial_hash;
   timeunit 1ns;
   timeprecision 1ps;
   import phash_pkg::*;

   localparam int IDLE_PCT       = 36;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int REPORT_LIMIT   = 10;
   localparam int TOTAL_ITEMS    = 400;

   localparam longint unsigned MOD_P = longint'(HASH_PRIME);
   localparam longint unsigned BASE  = 7;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [SYM_W-1:0] symbol;
      logic [IDX_W-1:0] left_index;
      logic [IDX_W-1:0] right_index;
   } hash_request_type;

   typedef struct packed {
      logic [PRIME_W-1:0]  prime;
      logic [WRAP_W-1:0]   wrap;
      logic [STATUS_W-1:0] status;
   } hash_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   phash_req_if req_if ();
   phash_rsp_if rsp_if ();

   prefix_polynomial_hash i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #5 clock = ~clock;

   hash_request_type request_queue[$];
   hash_result_type  expected_hashes[$];
   int               requests_total;
   int               requests_taken = 0;
   int               mismatches = 0;
   int               quiet_cycles = 0;
   int               gen_length = 0;
   bit               request_taken = 1'b0;
   logic             steady;

   longint unsigned prefix_mod_p [MAX_LEN];
   longint unsigned prefix_wrap  [MAX_LEN];
   longint unsigned power_mod_p  [MAX_LEN+1];
   longint unsigned power_wrap   [MAX_LEN+1];
   int              seq_length;

   // no idling at all over a stretch of requests
   assign steady = (requests_taken >= 150) && (requests_taken < 250);

   function automatic hash_result_type hash_step(hash_request_type rq);
      hash_result_type res;
      int              sym_off;
      int              l;
      int              r;
      int              k;
      longint unsigned vp;
      longint unsigned vw;
      longint unsigned hp;
      longint unsigned hw;
      longint unsigned sub;
      res = '0;
      res.status = ST_OK;
      case (rq.cmd)
         CMD_CLEAR: begin
            seq_length = 0;
         end
         CMD_APPEND: begin
            if (seq_length >= MAX_LEN) begin
               res.status = ST_FULL;
            end else begin
               sym_off = $signed(rq.symbol) + SYM_OFFSET;
               vw = longint'(sym_off);
               if (sym_off < 0) begin
                  vp = MOD_P - longint'(-sym_off);
               end else begin
                  vp = longint'(sym_off);
               end
               hp = 0;
               hw = 0;
               if (seq_length != 0) begin
                  hp = (prefix_mod_p[seq_length-1] * BASE) % MOD_P;
                  hw = prefix_wrap[seq_length-1] * BASE;
               end
               prefix_mod_p[seq_length] = (hp + vp) % MOD_P;
               prefix_wrap[seq_length]  = hw + vw;
               power_mod_p[seq_length+1] = (power_mod_p[seq_length] * BASE) % MOD_P;
               power_wrap[seq_length+1]  = power_wrap[seq_length] * BASE;
               seq_length++;
            end
         end
         CMD_QUERY: begin
            l = int'(rq.left_index);
            r = int'(rq.right_index);
            if (l > r || r >= seq_length) begin
               res.status = ST_RANGE;
            end else begin
               hp = prefix_mod_p[r];
               hw = prefix_wrap[r];
               if (l != 0) begin
                  k   = r - l + 1;
                  sub = (prefix_mod_p[l-1] * power_mod_p[k]) % MOD_P;
                  hp  = (hp + MOD_P - sub) % MOD_P;
                  hw  = hw - prefix_wrap[l-1] * power_wrap[k];
               end
               res.prime = PRIME_W'(hp);
               res.wrap  = hw;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic void note_mismatch(string what, logic [WRAP_W-1:0] exp_val,
                                         logic [WRAP_W-1:0] act_val);
      if (mismatches < REPORT_LIMIT) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_val, act_val);
      end
      mismatches++;
   endfunction

   // accepted requests and responses, sampled at the rising edge
   always @(posedge clock) begin
      hash_request_type rq;
      hash_result_type  exp_res;
      hash_result_type  pred_res;
      if (reset) begin
         seq_length     = 0;
         power_mod_p[0] = 1;
         power_wrap[0]  = 1;
         quiet_cycles   = 0;
      end else begin
         quiet_cycles++;
         if (req_if.valid && req_if.ready) begin
            rq.cmd         = req_if.cmd;
            rq.symbol      = req_if.symbol;
            rq.left_index  = req_if.left_index;
            rq.right_index = req_if.right_index;
            pred_res        = hash_step(rq);
            expected_hashes = {expected_hashes, pred_res};
            requests_taken++;
            request_taken = 1'b1;
            quiet_cycles  = 0;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            quiet_cycles = 0;
            if (expected_hashes.size() == 0) begin
               note_mismatch("unexpected response status", '0, WRAP_W'(rsp_if.status));
            end else begin
               exp_res = expected_hashes.pop_front();
               if (rsp_if.status !== exp_res.status) begin
                  note_mismatch("status", WRAP_W'(exp_res.status), WRAP_W'(rsp_if.status));
               end
               if (rsp_if.hash_prime !== exp_res.prime) begin
                  note_mismatch("hash_prime", WRAP_W'(exp_res.prime),
                                WRAP_W'(rsp_if.hash_prime));
               end
               if (rsp_if.hash_wrap !== exp_res.wrap) begin
                  note_mismatch("hash_wrap", exp_res.wrap, rsp_if.hash_wrap);
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // request driver and response back-pressure, driven at the falling edge
   always @(negedge clock) begin
      hash_request_type rq;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || request_taken) begin
         request_taken = 1'b0;
         if (request_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            rq = request_queue.pop_front();
            req_if.valid       <= 1'b1;
            req_if.cmd         <= rq.cmd;
            req_if.symbol      <= rq.symbol;
            req_if.left_index  <= rq.left_index;
            req_if.right_index <= rq.right_index;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= !reset && (steady || $urandom_range(99) >= IDLE_PCT);
   end

   task automatic add_request(logic [CMD_W-1:0] cmd, int sym, int li, int ri);
      hash_request_type rq;
      rq.cmd         = cmd;
      rq.symbol      = SYM_W'(sym);
      rq.left_index  = IDX_W'(li);
      rq.right_index = IDX_W'(ri);
      request_queue  = {request_queue, rq};
      if (cmd == CMD_CLEAR) begin
         gen_length = 0;
      end else if (cmd == CMD_APPEND && gen_length < MAX_LEN) begin
         gen_length++;
      end
   endtask

   task automatic add_valid_query();
      int r;
      int l;
      r = $urandom_range(gen_length - 1);
      l = ($urandom_range(4) == 0) ? 0 : $urandom_range(r);
      add_request(CMD_QUERY, 0, l, r);
   endtask

   initial begin
      int pick;
      req_if.valid       = 1'b0;
      req_if.cmd         = CMD_CLEAR;
      req_if.symbol      = '0;
      req_if.left_index  = '0;
      req_if.right_index = '0;
      rsp_if.ready       = 1'b0;

      // empty sequence, unused command, symbol extremes and offset edges
      add_request(CMD_QUERY, 0, 0, 0);
      add_request(CMD_NOP, 'h5A5A, 1023, 1023);
      add_request(CMD_APPEND, -32768, 0, 0);
      add_request(CMD_APPEND, 32767, 0, 0);
      add_request(CMD_APPEND, -3, 0, 0);
      add_request(CMD_APPEND, -4, 0, 0);
      add_request(CMD_APPEND, -2, 0, 0);
      add_request(CMD_APPEND, 0, 0, 0);
      add_request(CMD_QUERY, 0, 0, 5);
      add_request(CMD_QUERY, 0, 1, 5);
      add_request(CMD_QUERY, 0, 5, 5);
      add_request(CMD_QUERY, 0, 2, 4);
      add_request(CMD_QUERY, 0, 3, 2);
      add_request(CMD_QUERY, 0, 0, 6);
      add_request(CMD_QUERY, 0, 0, 1023);
      add_request(CMD_QUERY, 0, 0, 0);
      add_request(CMD_CLEAR, 0, 0, 0);
      add_request(CMD_QUERY, 0, 0, 0);
      add_request(CMD_APPEND, 32764, 0, 0);
      add_request(CMD_QUERY, 0, 0, 0);

      while (request_queue.size() < TOTAL_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            add_request(CMD_CLEAR, $urandom, $urandom, $urandom);
         end else if (pick < 9) begin
            add_request(CMD_NOP, $urandom, $urandom, $urandom);
         end else if (pick < 50 || gen_length == 0) begin
            add_request(CMD_APPEND, $urandom, $urandom, $urandom);
         end else if (pick < 88) begin
            add_valid_query();
         end else begin
            add_request(CMD_QUERY, $urandom, $urandom, $urandom);
         end
      end
      requests_total = request_queue.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (requests_taken < requests_total || expected_hashes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
